>>> hw/rtl/qapm_pkg.sv
// shared types, widths and constants of the attitude pid and motor mixer
package qapm_pkg;

	// field widths
	localparam int AW      = 13;  // angle, 1/16 degree, signed
	localparam int PITCH_W = 12;
	localparam int GAIN_W  = 16;  // q8.8 unsigned
	localparam int THR_W   = 12;
	localparam int MOTOR_W = 11;
	localparam int CNT_W   = 4;

	// internal widths
	localparam int DIFF_W  = AW + 1;
	localparam int SUM_W   = 16;
	localparam int SUMX_W  = SUM_W + 1;
	localparam int PROD_W  = 33;
	localparam int FRAC_W  = 12;
	localparam int TERM_W  = PROD_W - FRAC_W;
	localparam int AXIS_W  = TERM_W + 2;
	localparam int MIX_W   = AXIS_W + 2;

	localparam logic [CNT_W-1:0]   WINDOW    = CNT_W'(10);
	localparam logic [MOTOR_W-1:0] MOTOR_MIN = MOTOR_W'(1000);
	localparam logic [MOTOR_W-1:0] MOTOR_MAX = MOTOR_W'(1999);

	// register reset values
	localparam logic [GAIN_W-1:0] KP_TILT_RST    = GAIN_W'(1536);
	localparam logic [GAIN_W-1:0] KI_TILT_RST    = GAIN_W'(77);
	localparam logic [GAIN_W-1:0] KD_TILT_RST    = GAIN_W'(256);
	localparam logic [GAIN_W-1:0] KP_HEADING_RST = GAIN_W'(0);
	localparam logic [GAIN_W-1:0] KI_HEADING_RST = GAIN_W'(0);
	localparam logic [GAIN_W-1:0] KD_HEADING_RST = GAIN_W'(0);
	localparam logic [THR_W-1:0]  MIX_THR_RST    = THR_W'(1200);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP_TILT    = 3'd0,
		CFG_KI_TILT    = 3'd1,
		CFG_KD_TILT    = 3'd2,
		CFG_KP_HEADING = 3'd3,
		CFG_KI_HEADING = 3'd4,
		CFG_KD_HEADING = 3'd5,
		CFG_MIX_THR    = 3'd6
	} cfg_idx_t;

	// per-request control handed to each axis lane
	typedef struct packed {
		logic accept;
		logic sample_valid;
		logic win_done;
		logic en1;
		logic en2;
		logic en3;
	} lane_ctl_t;

endpackage

>>> hw/rtl/qapm_lane.sv
// one axis lane: held angle, window sum and the three-term pid pipeline
module qapm_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  qapm_pkg::lane_ctl_t                   ctl,
	input  logic signed [qapm_pkg::AW-1:0]        angle,
	input  logic [qapm_pkg::GAIN_W-1:0]           kp,
	input  logic [qapm_pkg::GAIN_W-1:0]           ki,
	input  logic [qapm_pkg::GAIN_W-1:0]           kd,
	output logic signed [qapm_pkg::AXIS_W-1:0]    axis_out
);

	localparam logic signed [qapm_pkg::SUM_W-1:0] SUM_MAX =
		{1'b0, {(qapm_pkg::SUM_W-1){1'b1}}};
	localparam logic signed [qapm_pkg::SUM_W-1:0] SUM_MIN =
		{1'b1, {(qapm_pkg::SUM_W-1){1'b0}}};

	logic signed [qapm_pkg::AW-1:0]     held_q;
	logic signed [qapm_pkg::SUM_W-1:0]  sum_q;

	logic signed [qapm_pkg::AW-1:0]     cur;
	logic signed [qapm_pkg::DIFF_W-1:0] diff;
	logic signed [qapm_pkg::SUMX_W-1:0] sum_ext;
	logic signed [qapm_pkg::SUM_W-1:0]  sum_sat;

	logic signed [qapm_pkg::AW-1:0]     e_s1;
	logic signed [qapm_pkg::DIFF_W-1:0] d_s1;
	logic signed [qapm_pkg::SUM_W-1:0]  i_s1;

	logic signed [qapm_pkg::PROD_W-1:0] pp;
	logic signed [qapm_pkg::PROD_W-1:0] pi;
	logic signed [qapm_pkg::PROD_W-1:0] pd;
	logic signed [qapm_pkg::PROD_W-1:0] pp_s2;
	logic signed [qapm_pkg::PROD_W-1:0] pi_s2;
	logic signed [qapm_pkg::PROD_W-1:0] pd_s2;

	logic signed [qapm_pkg::TERM_W-1:0] tp;
	logic signed [qapm_pkg::TERM_W-1:0] ti;
	logic signed [qapm_pkg::TERM_W-1:0] td;
	logic signed [qapm_pkg::AXIS_W-1:0] axis_s3;

	// invalid sample reuses the held angle
	always_comb begin
		cur     = ctl.sample_valid ? angle : held_q;
		diff    = qapm_pkg::DIFF_W'(cur) - qapm_pkg::DIFF_W'(held_q);
		sum_ext = qapm_pkg::SUMX_W'(sum_q) + qapm_pkg::SUMX_W'(cur);
		if (sum_ext[qapm_pkg::SUMX_W-1] != sum_ext[qapm_pkg::SUMX_W-2]) begin
			sum_sat = sum_ext[qapm_pkg::SUMX_W-1] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_ext[qapm_pkg::SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			sum_q  <= '0;
		end else if (ctl.accept) begin
			held_q <= cur;
			if (ctl.sample_valid) begin
				sum_q <= ctl.win_done ? '0 : sum_sat;
			end
		end
	end

	// gains are unsigned, widened with a zero sign bit
	assign pp = qapm_pkg::PROD_W'($signed({1'b0, kp})) * qapm_pkg::PROD_W'(e_s1);
	assign pi = qapm_pkg::PROD_W'($signed({1'b0, ki})) * qapm_pkg::PROD_W'(i_s1);
	assign pd = qapm_pkg::PROD_W'($signed({1'b0, kd})) * qapm_pkg::PROD_W'(d_s1);

	// arithmetic shift gives the floor of each term
	assign tp = qapm_pkg::TERM_W'(pp_s2 >>> qapm_pkg::FRAC_W);
	assign ti = qapm_pkg::TERM_W'(pi_s2 >>> qapm_pkg::FRAC_W);
	assign td = qapm_pkg::TERM_W'(pd_s2 >>> qapm_pkg::FRAC_W);

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			e_s1 <= cur;
			d_s1 <= diff;
			i_s1 <= ctl.win_done ? sum_sat : '0;
		end
		if (ctl.en2) begin
			pp_s2 <= pp;
			pi_s2 <= pi;
			pd_s2 <= pd;
		end
		if (ctl.en3) begin
			axis_s3 <= qapm_pkg::AXIS_W'(tp) + qapm_pkg::AXIS_W'(ti)
				+ qapm_pkg::AXIS_W'(td);
		end
	end

	assign axis_out = axis_s3;

endmodule

>>> hw/rtl/qapm_mixer.sv
// x-form motor mixer with saturation, radio cut-off and output register
module qapm_mixer (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [qapm_pkg::THR_W-1:0]           thr,
	input  logic                                 mix_en,
	input  logic                                 radio_ok,
	input  logic signed [qapm_pkg::AXIS_W-1:0]   roll,
	input  logic signed [qapm_pkg::AXIS_W-1:0]   pitch,
	input  logic signed [qapm_pkg::AXIS_W-1:0]   yaw,
	output logic [4*qapm_pkg::MOTOR_W-1:0]       motors
);

	localparam logic signed [qapm_pkg::MIX_W-1:0] LIM_LO =
		qapm_pkg::MIX_W'(qapm_pkg::MOTOR_MIN);
	localparam logic signed [qapm_pkg::MIX_W-1:0] LIM_HI =
		qapm_pkg::MIX_W'(qapm_pkg::MOTOR_MAX);

	logic signed [qapm_pkg::MIX_W-1:0]   t;
	logic signed [qapm_pkg::MIX_W-1:0]   r;
	logic signed [qapm_pkg::MIX_W-1:0]   p;
	logic signed [qapm_pkg::MIX_W-1:0]   y;
	logic signed [qapm_pkg::MIX_W-1:0]   m [4];
	logic [qapm_pkg::MOTOR_W-1:0]        sat [4];
	logic [4*qapm_pkg::MOTOR_W-1:0]      motors_q;

	always_comb begin
		t = qapm_pkg::MIX_W'($signed({1'b0, thr}));
		r = qapm_pkg::MIX_W'(roll);
		p = qapm_pkg::MIX_W'(pitch);
		y = qapm_pkg::MIX_W'(yaw);
		if (mix_en) begin
			m[0] = t - r - p + y;
			m[1] = t - r + p - y;
			m[2] = t + r + p + y;
			m[3] = t + r - p - y;
		end else begin
			for (int k = 0; k < 4; k++) begin
				m[k] = t;
			end
		end
		for (int k = 0; k < 4; k++) begin
			if (!radio_ok || m[k] < LIM_LO) begin
				sat[k] = qapm_pkg::MOTOR_MIN;
			end else if (m[k] > LIM_HI) begin
				sat[k] = qapm_pkg::MOTOR_MAX;
			end else begin
				sat[k] = m[k][qapm_pkg::MOTOR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			motors_q <= {sat[3], sat[2], sat[1], sat[0]};
		end
	end

	assign motors = motors_q;

endmodule

>>> hw/rtl/quad_attitude_pid_mixer_unit.sv
// top level of the quadcopter attitude pid with x-form motor mixer
//
// One attitude request per clock is taken while the output side is not
// stalling, and one set of four motor values is delivered per request, in
// order. Each passes a front stage that updates the held angle and window sum,
// a stage of three multipliers per lane (p, i, d side by side, a 17 bit gain
// by a 13, 16 or 14 bit operand), a stage that floors and adds the terms, and
// the mixer's output register. Three lanes (roll, pitch, yaw) run in parallel
// and the mixer merges them into the four motors. Each stage advances when the
// one after it is empty or moving, so requests keep flowing into bubbles while
// a finished result waits. Gains and the mix threshold are written through the
// config channel, which is always ready; write only while no request is in
// flight. Radio loss forces every motor to 1000 but still advances the state.
module quad_attitude_pid_mixer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qapm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qapm_pkg::CFG_DATA_W-1:0]     cfg_data,
	// attitude requests
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [55:0]                         s_tdata,  // roll_angle, pitch_angle, yaw_angle, throttle, zero pad
	input  logic [1:0]                          s_tuser,  // sample_valid, radio_ok
	// motor results
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [47:0]                         m_tdata   // motor_front_a, motor_front_b, motor_rear_a, motor_rear_b, zero pad
);

	// config registers
	logic [qapm_pkg::GAIN_W-1:0] kp_tilt_q;
	logic [qapm_pkg::GAIN_W-1:0] ki_tilt_q;
	logic [qapm_pkg::GAIN_W-1:0] kd_tilt_q;
	logic [qapm_pkg::GAIN_W-1:0] kp_heading_q;
	logic [qapm_pkg::GAIN_W-1:0] ki_heading_q;
	logic [qapm_pkg::GAIN_W-1:0] kd_heading_q;
	logic [qapm_pkg::THR_W-1:0]  mix_thr_q;

	// input fields
	logic signed [qapm_pkg::AW-1:0] roll_angle;
	logic signed [qapm_pkg::AW-1:0] pitch_angle;
	logic signed [qapm_pkg::AW-1:0] yaw_angle;
	logic [qapm_pkg::THR_W-1:0]     throttle;
	logic                           sample_valid;
	logic                           radio_ok;

	// window counter shared by the lanes
	logic [qapm_pkg::CNT_W-1:0] cnt_q;
	logic [qapm_pkg::CNT_W-1:0] cnt_inc;
	logic                       win_done;

	// pipeline occupancy and stage enables
	logic v1_q, v2_q, v3_q, ov_q;
	logic rd1, rd2, rd3, rd_out;
	logic accept;

	// throttle side-band alongside the lanes
	logic [qapm_pkg::THR_W-1:0] thr_s1, thr_s2, thr_s3;
	logic                       mix_s1, mix_s2, mix_s3;
	logic                       radio_s1, radio_s2, radio_s3;

	qapm_pkg::lane_ctl_t             ctl;
	logic signed [qapm_pkg::AXIS_W-1:0] roll_axis;
	logic signed [qapm_pkg::AXIS_W-1:0] pitch_axis;
	logic signed [qapm_pkg::AXIS_W-1:0] yaw_axis;
	logic [4*qapm_pkg::MOTOR_W-1:0]     motors;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_tilt_q    <= qapm_pkg::KP_TILT_RST;
			ki_tilt_q    <= qapm_pkg::KI_TILT_RST;
			kd_tilt_q    <= qapm_pkg::KD_TILT_RST;
			kp_heading_q <= qapm_pkg::KP_HEADING_RST;
			ki_heading_q <= qapm_pkg::KI_HEADING_RST;
			kd_heading_q <= qapm_pkg::KD_HEADING_RST;
			mix_thr_q    <= qapm_pkg::MIX_THR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				qapm_pkg::CFG_KP_TILT:    kp_tilt_q    <= cfg_data;
				qapm_pkg::CFG_KI_TILT:    ki_tilt_q    <= cfg_data;
				qapm_pkg::CFG_KD_TILT:    kd_tilt_q    <= cfg_data;
				qapm_pkg::CFG_KP_HEADING: kp_heading_q <= cfg_data;
				qapm_pkg::CFG_KI_HEADING: ki_heading_q <= cfg_data;
				qapm_pkg::CFG_KD_HEADING: kd_heading_q <= cfg_data;
				qapm_pkg::CFG_MIX_THR:    mix_thr_q    <= cfg_data[qapm_pkg::THR_W-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// unpack the request; pitch is sign-extended to the lane width
	assign roll_angle   = s_tdata[12:0];
	assign pitch_angle  = qapm_pkg::AW'($signed(s_tdata[24:13]));
	assign yaw_angle    = s_tdata[37:25];
	assign throttle     = s_tdata[49:38];
	assign sample_valid = s_tuser[0];
	assign radio_ok     = s_tuser[1];

	// a stage may load when it is empty or its contents move on
	assign rd_out   = !ov_q || m_tready;
	assign rd3      = !v3_q || rd_out;
	assign rd2      = !v2_q || rd3;
	assign rd1      = !v1_q || rd2;
	assign s_tready = rd1;
	assign accept   = s_tvalid && rd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (rd1) v1_q <= s_tvalid;
			if (rd2) v2_q <= v1_q;
			if (rd3) v3_q <= v2_q;
			if (rd_out) ov_q <= v3_q;
		end
	end

	// window closes on the valid sample that brings the count to the window size
	assign cnt_inc  = cnt_q + qapm_pkg::CNT_W'(1);
	assign win_done = sample_valid && (cnt_inc >= qapm_pkg::WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept && sample_valid) begin
			cnt_q <= win_done ? '0 : cnt_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (rd1) begin
			thr_s1   <= throttle;
			mix_s1   <= throttle > mix_thr_q;
			radio_s1 <= radio_ok;
		end
		if (rd2) begin
			thr_s2   <= thr_s1;
			mix_s2   <= mix_s1;
			radio_s2 <= radio_s1;
		end
		if (rd3) begin
			thr_s3   <= thr_s2;
			mix_s3   <= mix_s2;
			radio_s3 <= radio_s2;
		end
	end

	always_comb begin
		ctl.accept       = accept;
		ctl.sample_valid = sample_valid;
		ctl.win_done     = win_done;
		ctl.en1          = rd1;
		ctl.en2          = rd2;
		ctl.en3          = rd3;
	end

	// roll and pitch share the tilt gains, yaw uses the heading gains
	qapm_lane u_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.angle    (roll_angle),
		.kp       (kp_tilt_q),
		.ki       (ki_tilt_q),
		.kd       (kd_tilt_q),
		.axis_out (roll_axis)
	);

	qapm_lane u_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.angle    (pitch_angle),
		.kp       (kp_tilt_q),
		.ki       (ki_tilt_q),
		.kd       (kd_tilt_q),
		.axis_out (pitch_axis)
	);

	qapm_lane u_yaw (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.angle    (yaw_angle),
		.kp       (kp_heading_q),
		.ki       (ki_heading_q),
		.kd       (kd_heading_q),
		.axis_out (yaw_axis)
	);

	qapm_mixer u_mixer (
		.clk      (clk),
		.en       (rd_out),
		.thr      (thr_s3),
		.mix_en   (mix_s3),
		.radio_ok (radio_s3),
		.roll     (roll_axis),
		.pitch    (pitch_axis),
		.yaw      (yaw_axis),
		.motors   (motors)
	);

	assign m_tvalid = ov_q;
	assign m_tdata  = {4'b0000, motors};

endmodule

>>> hw/rtl/qapm_checker.sv
// port-level checks of the attitude pid and motor mixer, bound to the top level
module qapm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// requests taken but not yet delivered
	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled motor result changed");

	// no result without a request behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 3'd0)
		else $error("motor result with no pending request");

	// never more in flight than the pipeline holds
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("too many requests in flight");

	// every motor stays inside the pwm window
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[10:0] >= 11'd1000 && m_tdata[10:0] <= 11'd1999
			&& m_tdata[21:11] >= 11'd1000 && m_tdata[21:11] <= 11'd1999
			&& m_tdata[32:22] >= 11'd1000 && m_tdata[32:22] <= 11'd1999
			&& m_tdata[43:33] >= 11'd1000 && m_tdata[43:33] <= 11'd1999))
		else $error("motor value outside 1000..1999");

endmodule

bind quad_attitude_pid_mixer_unit qapm_checker u_qapm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
